[src/iat_pkg.sv]
package iat_pkg;

  // run modes, also the encoding of the run_mode field
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2,
    MODE_DONE  = 2'd3
  } mode_t;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TOTAL    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALERT    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STROBE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HOLD     = 3'd4;
  localparam int unsigned CfgDataW = 20;

  // register defaults after reset
  localparam logic [19:0] INTERVAL_RST = 20'd60000;
  localparam logic [5:0]  TOTAL_RST    = 6'd60;
  localparam logic [15:0] ALERT_RST    = 16'd6000;
  localparam logic [9:0]  STROBE_RST   = 10'd80;
  localparam logic [15:0] HOLD_RST     = 16'd900;

  // seconds conversion: remainders at or above this show the ceiling value
  localparam logic [25:0] REM_SAT      = 26'd1023000;
  localparam logic [9:0]  SECS_MAX     = 10'd1023;
  localparam logic [20:0] ROUND_UP     = 21'd999;
  // floor(y / 125) = (y * RECIP_125) >> 24, exact for y below 2^17
  localparam logic [17:0] RECIP_125    = 18'd134218;

  // work held between the state update and the seconds conversion
  typedef struct packed {
    mode_t       mode;
    logic        alerting;
    logic        light;
    logic [5:0]  shots;
    logic        pulse;
    logic        sat;
    logic [19:0] rem;
  } mid_t;

  // finished result
  typedef struct packed {
    mode_t       mode;
    logic        alerting;
    logic        light;
    logic [5:0]  shots;
    logic [9:0]  secs;
    logic        pulse;
  } res_t;

endpackage

[src/interval_alarm_timer_with_pause.sv]
// pipeline: an accepted tick transaction loads the middle register, and its result
//   is valid once it moves on from there into the result register
// throughput: one tick per cycle while in_stall is low; the state update and the registered
//   reciprocal multiply for the seconds value form a two-register pipeline
// reset: synchronous, active high; modes idle, light lit, counters cleared,
//   configuration registers at their defaults, pipeline empty
module interval_alarm_timer_with_pause (
  input  logic                             clk,
  input  logic                             rst,
  // tick channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             button_level,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       run_mode,
  output logic                             alerting,
  output logic                             backlight_on,
  output logic [5:0]                       shots_done,
  output logic [9:0]                       secs_left,
  output logic                             shot_pulse,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iat_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [iat_pkg::CfgDataW-1:0]     cfg_data
);

  // configuration registers
  logic [19:0] interval_ms;
  logic [5:0]  total_shots;
  logic [15:0] alert_len_ms;
  logic [9:0]  strobe_half_ms;
  logic [15:0] hold_len_ms;

  // timer state
  iat_pkg::mode_t mode, mode_next;
  logic [5:0]  shot_count, shot_count_next;
  logic [31:0] elapsed_ms, elapsed_ms_next;
  logic [25:0] next_due_ms, next_due_ms_next;
  logic        press_active, press_active_next;
  logic        hold_done, hold_done_next;
  logic [15:0] press_len, press_len_next;
  logic        alert_active, alert_active_next;
  logic [15:0] alert_spent, alert_spent_next;
  logic [9:0]  phase_ms, phase_ms_next;
  logic        light_level, light_level_next;

  // combinational helpers
  logic        press_edge;
  logic        press_hold_done;
  logic        held;
  logic        shot_fire;
  logic [5:0]  count_inc;
  logic [25:0] due_prod;
  logic [9:0]  half;
  logic [10:0] phase_inc;
  logic [16:0] spent_sum;
  logic        secs_active;
  logic [25:0] rem_full;

  // pipeline
  logic          in_accept;
  logic          mid_take;
  logic          out_take;
  logic          mid_valid;
  iat_pkg::mid_t mid, mid_next;
  iat_pkg::res_t res;
  logic [20:0]   rounded;
  logic [35:0]   quot_prod;
  logic [9:0]    quot;

  // handshake
  assign out_take  = !out_valid || !out_stall;
  assign mid_take  = !mid_valid || out_take;
  assign in_stall  = !mid_take;
  assign in_accept = in_valid && mid_take;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms    <= iat_pkg::INTERVAL_RST;
      total_shots    <= iat_pkg::TOTAL_RST;
      alert_len_ms   <= iat_pkg::ALERT_RST;
      strobe_half_ms <= iat_pkg::STROBE_RST;
      hold_len_ms    <= iat_pkg::HOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        iat_pkg::CFG_INTERVAL: interval_ms    <= cfg_data[19:0];
        iat_pkg::CFG_TOTAL:    total_shots    <= cfg_data[5:0];
        iat_pkg::CFG_ALERT:    alert_len_ms   <= cfg_data[15:0];
        iat_pkg::CFG_STROBE:   strobe_half_ms <= cfg_data[9:0];
        iat_pkg::CFG_HOLD:     hold_len_ms    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // press tracking, every tick in every mode
  always_comb begin
    press_active_next = press_active;
    press_hold_done   = hold_done;
    press_len_next    = press_len;
    press_edge        = 1'b0;
    if (button_level && !press_active) begin
      press_active_next = 1'b1;
      press_hold_done   = 1'b0;
      press_len_next    = '0;
      press_edge        = 1'b1;
    end else if (!button_level) begin
      press_active_next = 1'b0;
    end else if (press_len != 16'hFFFF) begin
      press_len_next = press_len + 16'd1;
    end
  end

  assign held = button_level && !press_hold_done && (press_len_next >= hold_len_ms);

  // shot arithmetic
  assign count_inc = shot_count + 6'd1;
  assign due_prod  = 26'(count_inc) * 26'(interval_ms);
  assign half      = (strobe_half_ms == '0) ? 10'd1 : strobe_half_ms;
  assign phase_inc = {1'b0, phase_ms} + 11'd1;
  assign spent_sum = {1'b0, alert_spent} + {7'b0, half};

  // mode and timer update
  always_comb begin
    mode_next         = mode;
    shot_count_next   = shot_count;
    elapsed_ms_next   = elapsed_ms;
    next_due_ms_next  = next_due_ms;
    hold_done_next    = press_hold_done;
    alert_active_next = alert_active;
    alert_spent_next  = alert_spent;
    phase_ms_next     = phase_ms;
    light_level_next  = light_level;
    shot_fire         = 1'b0;
    case (mode)
      iat_pkg::MODE_IDLE: begin
        if (press_edge) begin
          shot_count_next   = '0;
          elapsed_ms_next   = '0;
          next_due_ms_next  = '0;
          alert_active_next = 1'b0;
          alert_spent_next  = '0;
          phase_ms_next     = '0;
          light_level_next  = 1'b1;
          mode_next         = iat_pkg::MODE_RUN;
        end
      end
      iat_pkg::MODE_RUN: begin
        if (elapsed_ms != 32'hFFFF_FFFF) begin
          elapsed_ms_next = elapsed_ms + 32'd1;
        end
        if (alert_active) begin
          // strobe in progress: a press cuts it short
          if (button_level) begin
            alert_active_next = 1'b0;
            alert_spent_next  = '0;
            phase_ms_next     = '0;
            light_level_next  = 1'b1;
            if (shot_count >= total_shots) begin
              mode_next = iat_pkg::MODE_DONE;
            end
          end else if (phase_inc >= {1'b0, half}) begin
            phase_ms_next = '0;
            if (spent_sum >= {1'b0, alert_len_ms}) begin
              alert_active_next = 1'b0;
              alert_spent_next  = '0;
              light_level_next  = 1'b1;
              if (shot_count >= total_shots) begin
                mode_next = iat_pkg::MODE_DONE;
              end
            end else begin
              alert_spent_next = spent_sum[15:0];
              light_level_next = !light_level;
            end
          end else begin
            phase_ms_next = phase_inc[9:0];
          end
        end else if (held) begin
          hold_done_next = 1'b1;
          mode_next      = iat_pkg::MODE_PAUSE;
        end else if (elapsed_ms_next >= {6'b0, next_due_ms}) begin
          // shot due
          shot_fire        = 1'b1;
          shot_count_next  = count_inc;
          next_due_ms_next = due_prod;
          if (alert_len_ms == '0) begin
            if (count_inc >= total_shots) begin
              mode_next = iat_pkg::MODE_DONE;
            end
          end else begin
            alert_active_next = 1'b1;
            alert_spent_next  = '0;
            phase_ms_next     = '0;
            light_level_next  = 1'b0;
          end
        end
      end
      iat_pkg::MODE_PAUSE: begin
        if (held) begin
          hold_done_next   = 1'b1;
          light_level_next = 1'b1;
          mode_next        = iat_pkg::MODE_IDLE;
        end else if (press_edge) begin
          mode_next = iat_pkg::MODE_RUN;
        end
      end
      default: begin
        if (press_edge) begin
          mode_next = iat_pkg::MODE_IDLE;
        end
      end
    endcase
  end

  // time to the next shot in milliseconds, after the update
  assign secs_active = ((mode_next == iat_pkg::MODE_RUN) || (mode_next == iat_pkg::MODE_PAUSE))
                       && (elapsed_ms_next < {6'b0, next_due_ms_next});
  assign rem_full    = secs_active ? (next_due_ms_next - elapsed_ms_next[25:0]) : '0;

  always_comb begin
    mid_next.mode     = mode_next;
    mid_next.alerting = alert_active_next;
    mid_next.light    = light_level_next;
    mid_next.shots    = shot_count_next;
    mid_next.pulse    = shot_fire;
    mid_next.sat      = (rem_full >= iat_pkg::REM_SAT);
    mid_next.rem      = rem_full[19:0];
  end

  // state registers, updated once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= iat_pkg::MODE_IDLE;
      shot_count   <= '0;
      elapsed_ms   <= '0;
      next_due_ms  <= '0;
      press_active <= 1'b0;
      hold_done    <= 1'b0;
      press_len    <= '0;
      alert_active <= 1'b0;
      alert_spent  <= '0;
      phase_ms     <= '0;
      light_level  <= 1'b1;
    end else if (in_accept) begin
      mode         <= mode_next;
      shot_count   <= shot_count_next;
      elapsed_ms   <= elapsed_ms_next;
      next_due_ms  <= next_due_ms_next;
      press_active <= press_active_next;
      hold_done    <= hold_done_next;
      press_len    <= press_len_next;
      alert_active <= alert_active_next;
      alert_spent  <= alert_spent_next;
      phase_ms     <= phase_ms_next;
      light_level  <= light_level_next;
    end
  end

  // middle stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_take) begin
      mid_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mid <= mid_next;
    end
  end

  // ceiling divide by 1000: floor((rem + 999) / 8 / 125) by reciprocal
  assign rounded   = {1'b0, mid.rem} + iat_pkg::ROUND_UP;
  assign quot_prod = 36'(rounded[20:3]) * 36'(iat_pkg::RECIP_125);
  assign quot      = quot_prod[33:24];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && mid_valid) begin
      res.mode     <= mid.mode;
      res.alerting <= mid.alerting;
      res.light    <= mid.light;
      res.shots    <= mid.shots;
      res.secs     <= mid.sat ? iat_pkg::SECS_MAX : quot;
      res.pulse    <= mid.pulse;
    end
  end

  assign run_mode     = res.mode;
  assign alerting     = res.alerting;
  assign backlight_on = res.light;
  assign shots_done   = res.shots;
  assign secs_left    = res.secs;
  assign shot_pulse   = res.pulse;

endmodule
